>>> rtl/convolution_tail_sum_defines.svh
// Assertion macros shared by the convolution tail sum RTL.
`ifndef CONVOLUTION_TAIL_SUM_DEFINES_SVH
`define CONVOLUTION_TAIL_SUM_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cts_pkg.sv
// Types and constants of the convolution tail sum block.
package cts_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 31;
  localparam int FREQ_W   = 16;
  localparam int THRESH_W = 32;
  localparam int SUM_W    = 48;
  localparam int STAT_W   = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_A = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_AB = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY_AA = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [FREQ_W-1:0]  freq;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear;
    logic append_a;
    logic append_b;
    logic start;
    logic self_query;
    logic scan;
    logic post_imm;
    logic post_sum;
  } cts_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic x_empty;
    logic scan_done;
  } cts_stat_t;

endpackage

>>> rtl/cts_datapath.sv
// Table memories, two-pointer walk, suffix sum, product and accumulator.
module cts_datapath import cts_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cts_cmd_t                   cmd_i,
  output cts_stat_t                  stat_o,
  input  logic signed [VALUE_W-1:0]  entry_value_i,
  input  logic [FREQ_W-1:0]          entry_freq_i,
  input  logic signed [THRESH_W-1:0] threshold_i,
  output logic [SUM_W-1:0]           tail_sum_o,
  output logic [STAT_W-1:0]          status_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = FREQ_W + CW;
  localparam int PW = SW + FREQ_W;

  entry_t a_mem_q [TABLE_DEPTH];
  entry_t b_mem_q [TABLE_DEPTH];
  entry_t a_x_rd_q, a_y_rd_q, b_y_rd_q;
  entry_t new_entry, y_rd;

  logic [CW-1:0] a_count_q, a_count_d, b_count_q, b_count_d;
  logic signed [VALUE_W-1:0] a_last_q, b_last_q;
  logic [CW-1:0] i_q, i_d, j_q, j_d, i_plus, jm1;
  logic [AW-1:0] x_addr, y_addr;
  logic [SW-1:0] s_q, s_d;
  logic [PW-1:0] prod_q;
  logic          prod_vld_q;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W:0]   acc_ext;
  logic          self_q;
  logic signed [THRESH_W-1:0] thresh_q;
  logic [THRESH_W-1:0] pair_sum;
  logic          ge, dec, adv;
  logic          a_full, a_order, b_full, b_order, a_we, b_we;
  logic [STAT_W-1:0] a_stat, b_stat, imm_stat;
  logic [SUM_W-1:0]  tail_q;
  logic [STAT_W-1:0] status_q;

  // Append checks: full first, then order against the last stored value.
  assign a_full  = a_count_q == CW'(TABLE_DEPTH);
  assign b_full  = b_count_q == CW'(TABLE_DEPTH);
  assign a_order = (a_count_q != '0) && (entry_value_i < a_last_q);
  assign b_order = (b_count_q != '0) && (entry_value_i < b_last_q);
  assign a_stat  = a_full ? ST_FULL : (a_order ? ST_ORDER : ST_OK);
  assign b_stat  = b_full ? ST_FULL : (b_order ? ST_ORDER : ST_OK);
  assign a_we    = cmd_i.append_a && (a_stat == ST_OK);
  assign b_we    = cmd_i.append_b && (b_stat == ST_OK);
  assign imm_stat = cmd_i.append_a ? a_stat : (cmd_i.append_b ? b_stat : ST_OK);
  assign new_entry = '{value: entry_value_i, freq: entry_freq_i};

  always_comb begin
    a_count_d = a_count_q;
    b_count_d = b_count_q;
    if (cmd_i.clear) begin
      a_count_d = '0;
      b_count_d = '0;
    end else begin
      if (a_we) a_count_d = a_count_q + CW'(1);
      if (b_we) b_count_d = b_count_q + CW'(1);
    end
  end

  // Walk step: x at i, y at j-1. Move j down while the pair qualifies,
  // otherwise retire x with the current suffix sum and move i up.
  assign y_rd     = self_q ? a_y_rd_q : b_y_rd_q;
  assign pair_sum = {a_x_rd_q.value[VALUE_W-1], a_x_rd_q.value}
                  + {y_rd.value[VALUE_W-1], y_rd.value};
  assign ge       = $signed(pair_sum) >= thresh_q;
  assign dec      = cmd_i.scan && (j_q != '0) && ge;
  assign adv      = cmd_i.scan && !dec;
  assign i_plus   = i_q + CW'(1);

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    s_d = s_q;
    if (cmd_i.start) begin
      i_d = '0;
      j_d = cmd_i.self_query ? a_count_q : b_count_q;
      s_d = '0;
    end else if (dec) begin
      j_d = j_q - CW'(1);
      s_d = s_q + SW'(y_rd.freq);
    end else if (adv) begin
      i_d = i_plus;
    end
  end

  // Addresses come from the next pointers so the read registers track them.
  assign jm1    = j_d - CW'(1);
  assign x_addr = i_d[AW-1:0];
  assign y_addr = jm1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem_q[a_count_q[AW-1:0]] <= new_entry;
    if (b_we) b_mem_q[b_count_q[AW-1:0]] <= new_entry;
    a_x_rd_q <= a_mem_q[x_addr];
    a_y_rd_q <= a_mem_q[y_addr];
    b_y_rd_q <= b_mem_q[y_addr];
  end

  assign acc_ext = {1'b0, acc_q} + (SUM_W+1)'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_ext[SUM_W] ? '1 : acc_ext[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_count_q  <= '0;
      b_count_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      a_count_q  <= a_count_d;
      b_count_q  <= b_count_d;
      i_q        <= i_d;
      j_q        <= j_d;
      prod_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) a_last_q <= entry_value_i;
    if (b_we) b_last_q <= entry_value_i;
    if (cmd_i.start) begin
      self_q   <= cmd_i.self_query;
      thresh_q <= threshold_i;
    end
    s_q    <= s_d;
    prod_q <= PW'(s_q) * PW'(a_x_rd_q.freq);
    acc_q  <= acc_d;
    if (cmd_i.post_imm) begin
      tail_q   <= '0;
      status_q <= imm_stat;
    end else if (cmd_i.post_sum) begin
      tail_q   <= acc_q;
      status_q <= ST_OK;
    end
  end

  assign stat_o.x_empty   = a_count_q == '0;
  assign stat_o.scan_done = adv && (i_plus == a_count_q);
  assign tail_sum_o       = tail_q;
  assign status_o         = status_q;

endmodule

>>> rtl/cts_ctrl.sv
// Command decoder, query sequencer and output handshake.
module cts_ctrl import cts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cts_stat_t        stat_i,
  output cts_cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free, accept;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i) inside
            CMD_QUERY_AB, CMD_QUERY_AA: begin
              // empty A answers zero at once
              if (stat_i.x_empty) begin
                cmd_o.post_imm = 1'b1;
              end else begin
                cmd_o.start      = 1'b1;
                cmd_o.self_query = command_i == CMD_QUERY_AA;
                state_d          = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.post_imm = 1'b1;
            end
            CMD_APPEND_A: begin
              cmd_o.append_a = 1'b1;
              cmd_o.post_imm = 1'b1;
            end
            CMD_APPEND_B: begin
              cmd_o.append_b = 1'b1;
              cmd_o.post_imm = 1'b1;
            end
            default: begin
              cmd_o.post_imm = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_POST;
      end
      S_POST: begin
        if (slot_free) begin
          cmd_o.post_sum = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.post_imm || cmd_o.post_sum) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/convolution_tail_sum.sv
// Convolution tail sum: clear, append and query over two frequency tables.
// Appends, clears, unused commands and any query while table A is empty give
// their item in the cycle after acceptance, and the next item can be taken in
// the cycle that this result is accepted. A query walks both tables with two
// pointers, one pointer move per cycle through the table memories, so the walk
// makes n_a + d pointer moves, where n_a is the entry count of A and d <= n_y
// is the number of entries of the second table that qualify for the largest A
// value. The sum then passes the DRAIN and POST states to the result
// register. One item is in work at a time. Table contents are not cleared;
// clear only resets the counts.
`include "convolution_tail_sum_defines.svh"

module convolution_tail_sum import cts_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [CMD_W-1:0]           command_i,
  input  logic signed [VALUE_W-1:0]  entry_value_i,
  input  logic [FREQ_W-1:0]          entry_freq_i,
  input  logic signed [THRESH_W-1:0] threshold_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [SUM_W-1:0]           tail_sum_o,
  output logic [STAT_W-1:0]          status_o
);

  cts_cmd_t  cmd;
  cts_stat_t stat;

  cts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_value_i (entry_value_i),
    .entry_freq_i  (entry_freq_i),
    .threshold_i   (threshold_i),
    .tail_sum_o    (tail_sum_o),
    .status_o      (status_o)
  );

  `CTS_ASSERT_IMP(a_no_accept_in_scan, cmd.scan, !in_ready_o, "item accepted in a query walk")
  `CTS_ASSERT_IMP(a_status_code, out_valid_o, status_o <= ST_ORDER, "bad status code")
  `CTS_ASSERT_IMP(a_err_zero_sum, out_valid_o && status_o != ST_OK, tail_sum_o == '0, "error sum")
  `CTS_ASSERT_NXT(a_start_busy, cmd.start, !in_ready_o && cmd.scan, "query did not start")

endmodule

>>> tb/convolution_tail_sum_tb.sv
// Self-checking testbench of convolution_tail_sum: loads, order and full flags, queries.
module convolution_tail_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  localparam int TABLE_DEPTH    = 256;
  localparam int ITEM_TARGET    = 1150;
  localparam int IDLE_PCT       = 27;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
  localparam int TAB_A          = 0;
  localparam int TAB_B          = 1;
  localparam int CMD_UNUSED_LO  = 5;
  localparam int CMD_UNUSED_HI  = 7;

  localparam longint VAL_MIN = -64'sd1073741824;
  localparam longint VAL_MAX = 64'sd1073741823;
  localparam longint THR_MIN = -64'sd2147483648;
  localparam longint THR_MAX = 64'sd2147483647;

  class tail_sum_scoreboard;
    typedef struct {
      logic [SUM_W-1:0]  sum;
      logic [STAT_W-1:0] status;
    } result_t;

    localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

    logic signed [VALUE_W-1:0] vals[2][TABLE_DEPTH];
    logic [FREQ_W-1:0]         frqs[2][TABLE_DEPTH];
    int unsigned               cnt[2];
    result_t                   pending_results[$];
    int                        errors;

    function new();
      cnt    = '{0, 0};
      errors = 0;
    endfunction

    function logic [STAT_W-1:0] table_append(int t, logic signed [VALUE_W-1:0] v,
                                             logic [FREQ_W-1:0] f);
      if (cnt[t] >= TABLE_DEPTH) return ST_FULL;
      if (cnt[t] > 0 && v < vals[t][cnt[t]-1]) return ST_ORDER;
      vals[t][cnt[t]] = v;
      frqs[t][cnt[t]] = f;
      cnt[t]++;
      return ST_OK;
    endfunction

    // Sum of f_x * f_y over pairs whose values add up to at least q, saturated.
    function longint unsigned tail_sum_over(int x, int y, longint q);
      longint unsigned acc;
      longint unsigned part;
      acc = 0;
      for (int i = 0; i < int'(cnt[x]); i++) begin
        part = 0;
        for (int j = 0; j < int'(cnt[y]); j++) begin
          if (longint'(vals[x][i]) + longint'(vals[y][j]) >= q) part += frqs[y][j];
        end
        acc += part * frqs[x][i];
        if (acc > SUM_MAX) acc = SUM_MAX;
      end
      return acc;
    endfunction

    function void apply_item(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v,
                             logic [FREQ_W-1:0] f, logic signed [THRESH_W-1:0] q);
      result_t r;
      r.sum    = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_CLEAR:    cnt = '{0, 0};
        CMD_APPEND_A: r.status = table_append(TAB_A, v, f);
        CMD_APPEND_B: r.status = table_append(TAB_B, v, f);
        CMD_QUERY_AB: r.sum = tail_sum_over(TAB_A, TAB_B, q);
        CMD_QUERY_AA: r.sum = tail_sum_over(TAB_A, TAB_A, q);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [SUM_W-1:0] sum, logic [STAT_W-1:0] st);
      result_t r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, tail_sum %0d status %0d", $time, sum, st);
        return;
      end
      r = pending_results.pop_front();
      if (sum !== r.sum) begin
        errors++;
        $display("%0t: tail_sum expected %0d, got %0d", $time, r.sum, sum);
      end
      if (st !== r.status) begin
        errors++;
        $display("%0t: status expected %0d, got %0d", $time, r.status, st);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           command     = '0;
  logic signed [VALUE_W-1:0]  entry_value = '0;
  logic [FREQ_W-1:0]          entry_freq  = '0;
  logic signed [THRESH_W-1:0] threshold   = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [SUM_W-1:0]           tail_sum;
  logic [STAT_W-1:0]          status;

  tail_sum_scoreboard sb = new();

  int     items_sent   = 0;
  int     stall_cycles = 0;
  bit     no_idle      = 1'b0;
  bit     hold_out     = 1'b0;
  longint gen_last[2];
  int     gen_cnt[2]   = '{0, 0};
  longint gen_vals[2][$];

  convolution_tail_sum #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .entry_value_i (entry_value),
    .entry_freq_i  (entry_freq),
    .threshold_i   (threshold),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .tail_sum_o    (tail_sum),
    .status_o      (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.apply_item(command, entry_value, entry_freq, threshold);
      if (out_valid && out_ready) sb.check_result(tail_sum, status);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random backpressure, one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic longint rand_span(longint lo, longint hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + longint'(r % longint'(hi - lo + 1));
  endfunction

  function automatic longint rand_thr();
    return longint'(int'($urandom));
  endfunction

  function automatic int unsigned rand_freq();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // Thresholds mostly sit right around an actual pair sum so the scan boundary moves.
  function automatic longint query_thr(int x, int y);
    longint s;
    case ($urandom_range(9))
      0:       return THR_MIN;
      1:       return THR_MAX;
      2, 3:    return rand_thr();
      default: begin
        if (gen_vals[x].size() == 0 || gen_vals[y].size() == 0) return rand_thr();
        s = gen_vals[x][$urandom_range(0, gen_vals[x].size() - 1)]
          + gen_vals[y][$urandom_range(0, gen_vals[y].size() - 1)] + rand_span(-2, 2);
        if (s < THR_MIN) s = THR_MIN;
        if (s > THR_MAX) s = THR_MAX;
        return s;
      end
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, longint v, int unsigned f, longint q);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_value <= v[VALUE_W-1:0];
    entry_freq  <= f[FREQ_W-1:0];
    threshold   <= q[THRESH_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic clear_tables();
    send_item(CMD_CLEAR, rand_span(VAL_MIN, VAL_MAX), rand_freq(), rand_thr());
    gen_cnt = '{0, 0};
    gen_vals[TAB_A].delete();
    gen_vals[TAB_B].delete();
  endtask

  // In-order append; left is how many appends this table still gets in the sequence, this one included.
  task automatic append_to(int t, bit wide, int left);
    longint room;
    longint step_max;
    longint v;
    if (gen_cnt[t] == 0) begin
      v = wide ? rand_span(VAL_MIN, VAL_MAX) : rand_span(-500, 500);
    end else begin
      room     = VAL_MAX - gen_last[t];
      step_max = wide ? room / left : ((room < 40) ? room : 40);
      v        = gen_last[t] + (($urandom_range(3) == 0) ? 0 : rand_span(0, step_max));
    end
    send_item((t == TAB_A) ? CMD_APPEND_A : CMD_APPEND_B, v, rand_freq(), rand_thr());
    if (gen_cnt[t] < TABLE_DEPTH) begin
      gen_last[t] = v;
      gen_cnt[t]++;
      gen_vals[t].push_back(v);
    end
  endtask

  task automatic append_disorder(int t);
    if (gen_cnt[t] == 0 || gen_last[t] == VAL_MIN) begin
      append_to(t, 1'b1, 1);
    end else begin
      send_item((t == TAB_A) ? CMD_APPEND_A : CMD_APPEND_B,
                rand_span(VAL_MIN, gen_last[t] - 1), rand_freq(), rand_thr());
    end
  endtask

  task automatic run_query();
    bit self_join;
    self_join = ($urandom_range(1) == 1);
    send_item(self_join ? CMD_QUERY_AA : CMD_QUERY_AB, rand_span(VAL_MIN, VAL_MAX),
              rand_freq(), query_thr(TAB_A, self_join ? TAB_A : TAB_B));
  endtask

  task automatic send_unused();
    logic [CMD_W-1:0] c;
    c = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    send_item(c, rand_span(VAL_MIN, VAL_MAX), rand_freq(), rand_thr());
  endtask

  task automatic small_sequence();
    int  na;
    int  nb;
    int  noise;
    bit  wide;
    if ($urandom_range(9) < 7) clear_tables();
    wide = ($urandom_range(1) == 1);
    na   = $urandom_range(0, 12);
    nb   = $urandom_range(0, 12);
    while (na + nb > 0) begin
      noise = $urandom_range(99);
      if (noise < 6) begin
        append_disorder($urandom_range(1));
      end else if (noise < 10) begin
        send_unused();
      end else if (na > 0 && (nb == 0 || $urandom_range(1))) begin
        append_to(TAB_A, wide, na);
        na--;
      end else begin
        append_to(TAB_B, wide, nb);
        nb--;
      end
    end
    repeat ($urandom_range(2, 6)) run_query();
  endtask

  // Fill one table to capacity; the last two appends hit the full flag, one of them out of order.
  task automatic fill_sequence(int t);
    clear_tables();
    for (int k = TABLE_DEPTH; k > 0; k--) append_to(t, 1'b1, k);
    append_to(t, 1'b1, 1);
    append_disorder(t);
    for (int k = 12; k > 0; k--) append_to(1 - t, 1'b1, k);
    repeat (6) run_query();
  endtask

  task automatic directed_items();
    send_item(CMD_QUERY_AB, 0, 0, 0);
    send_item(CMD_QUERY_AA, VAL_MAX, 16'hFFFF, THR_MIN);
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) begin
      send_item(CMD_W'(c), -1, 16'hFFFF, -1);
    end
    send_item(CMD_APPEND_A, VAL_MIN, 16'hFFFF, 0);
    send_item(CMD_QUERY_AB, 0, 0, THR_MIN);             // B still empty
    send_item(CMD_APPEND_A, VAL_MIN, 0, 0);             // equal value is fine
    send_item(CMD_APPEND_A, 0, 1, 0);
    send_item(CMD_APPEND_A, VAL_MAX, 16'hFFFF, 0);
    send_item(CMD_APPEND_A, 5, 7, 0);                   // below last entry
    send_item(CMD_APPEND_B, VAL_MIN, 16'hFFFF, 0);
    send_item(CMD_APPEND_B, VAL_MAX, 1, 0);
    send_item(CMD_APPEND_B, -1, 3, 0);                  // below last entry
    send_item(CMD_QUERY_AB, 0, 0, THR_MIN);
    send_item(CMD_QUERY_AB, 0, 0, THR_MAX);
    send_item(CMD_QUERY_AB, 0, 0, THR_MAX - 1);
    send_item(CMD_QUERY_AB, 0, 0, 0);
    send_item(CMD_QUERY_AA, 0, 0, THR_MIN);
    send_item(CMD_QUERY_AA, 0, 0, THR_MAX - 1);
    send_item(CMD_QUERY_AA, 0, 0, -1);
    send_item(CMD_CLEAR, 0, 0, 0);
    send_item(CMD_APPEND_B, 7, 3, 0);
    send_item(CMD_QUERY_AB, 0, 0, THR_MIN);             // A empty
    send_item(CMD_QUERY_AA, 0, 0, THR_MIN);
    send_item(CMD_CLEAR, 0, 0, 0);
  endtask

  initial begin
    int seq;
    seq = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    fill_sequence(TAB_A);
    while (items_sent < ITEM_TARGET) begin
      if (seq == 4) hold_out = 1'b1;
      no_idle = (seq >= 10 && seq < 17);
      if (seq == 20) fill_sequence(TAB_B);
      else small_sequence();
      if (seq == 8 || $urandom_range(9) == 0) drain_results();
      seq++;
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
